@@ hdl/hbridge_pulse_sequencer_unit_macros.svh @@
// Assertion macros shared by the checker of the H-bridge pulse sequencer
`ifndef HBRIDGE_PULSE_SEQUENCER_UNIT_MACROS_SVH
`define HBRIDGE_PULSE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define HPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hps checker: same-cycle rule broken");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define HPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hps checker: next-cycle rule broken");

`endif

@@ hdl/hps_pkg.sv @@
// Package of the H-bridge pulse sequencer: sizes, command bytes, job type, frame packing
package hps_pkg;

    localparam int BOARDS  = 1;
    localparam int CHIPS   = BOARDS * 3;
    localparam int BRIDGES = BOARDS * 9;
    localparam int CHIP_W  = (CHIPS > 1) ? $clog2(CHIPS) : 1;

    // Receive command bytes
    localparam logic [7:0] CMD_CONF  = 8'h80;
    localparam logic [7:0] CMD_STATE = 8'h81;
    localparam logic [7:0] CMD_END   = 8'h82;

    // Pulse length after reset
    localparam logic [15:0] LEN_RESET = 16'd1000;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    // One loop pass as handed from front to back
    typedef struct packed {
        logic [31:0]        time_now;
        logic [15:0]        up;
        logic [15:0]        gap;
        logic [15:0]        down;
        logic [15:0]        pause;
        logic [BRIDGES-1:0] bridge_on;
    } t_job;

    // Pack one chip's driver bits (enables 2..0, directions 5..3) into a driver word
    function automatic logic [15:0] frame_of(input logic [5:0] bits);
        logic [5:0] en6;
        logic [5:0] cc;
        en6 = '0;
        cc  = '0;
        for (int j = 0; j < 3; j++) begin
            en6[2*j]   = bits[j];
            en6[2*j+1] = bits[j];
            cc[2*j]    = bits[j+3];
            cc[2*j+1]  = ~bits[j+3];
        end
        return {3'b000, en6[5:1], en6[0], cc, 1'b0};
    endfunction

endpackage

@@ hdl/hps_front.sv @@
// Front part: command byte receiver holding lengths and bridge states, builds jobs
module hps_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_func,
    input  logic [7:0]    i_rx_byte,
    input  logic [31:0]   i_time_now,
    output hps_pkg::t_job o_job
);
    import hps_pkg::*;

    typedef enum logic [2:0] {
        RX_IDLE  = 3'b001,
        RX_STATE = 3'b010,
        RX_CONF  = 3'b100
    } t_rx_mode;

    t_rx_mode           r_mode, n_mode;
    logic [7:0]         r_count, n_count;
    logic [15:0]        r_pend [4];
    logic [15:0]        n_pend [4];
    logic [15:0]        r_len [4];
    logic [15:0]        n_len [4];
    logic [BRIDGES-1:0] r_on, n_on;

    // Decode the received byte against the current mode
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_pend  = r_pend;
        n_len   = r_len;
        n_on    = r_on;
        if (i_accept && i_func) begin
            case (r_mode)
                RX_CONF: begin
                    if (r_count[7:3] == 5'd0) begin
                        if (r_count[0]) begin
                            n_pend[r_count[2:1]] = r_pend[r_count[2:1]] | {i_rx_byte, 8'h00};
                        end else begin
                            n_pend[r_count[2:1]] = r_pend[r_count[2:1]] | {8'h00, i_rx_byte};
                        end
                    end
                    if (r_count >= 8'd7) begin
                        n_len  = n_pend;
                        n_mode = RX_IDLE;
                    end
                    if (r_count != 8'hFF) begin
                        n_count = r_count + 8'd1;
                    end
                end
                RX_STATE: begin
                    if (i_rx_byte == CMD_END) begin
                        n_mode = RX_IDLE;
                    end else begin
                        // even bytes carry seven bridges of a group, odd bytes the last two
                        for (int b = 0; b < BRIDGES; b++) begin
                            if (r_count[7:1] == 7'(b / 9)) begin
                                if ((!r_count[0] && (b % 9) < 7) ||
                                    (r_count[0] && (b % 9) >= 7)) begin
                                    n_on[b] = i_rx_byte[(b % 9) % 7];
                                end
                            end
                        end
                        if (r_count != 8'hFF) begin
                            n_count = r_count + 8'd1;
                        end
                    end
                end
                default: begin
                    n_count = 8'd0;
                    if (i_rx_byte == CMD_CONF) begin
                        n_mode = RX_CONF;
                        for (int k = 0; k < 4; k++) begin
                            n_pend[k] = 16'd0;
                        end
                    end else if (i_rx_byte == CMD_STATE) begin
                        n_mode = RX_STATE;
                    end else begin
                        n_mode = RX_IDLE;
                    end
                end
            endcase
        end
    end

    // Hold receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RX_IDLE;
            r_count <= 8'd0;
            r_on    <= '0;
            for (int k = 0; k < 4; k++) begin
                r_pend[k] <= 16'd0;
            end
            r_len[0] <= LEN_RESET;
            r_len[1] <= 16'd0;
            r_len[2] <= LEN_RESET;
            r_len[3] <= 16'd0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_len   <= n_len;
            r_on    <= n_on;
        end
    end

    // Build the job from the state after this byte
    assign o_job.time_now  = i_time_now;
    assign o_job.up        = n_len[0];
    assign o_job.gap       = n_len[1];
    assign o_job.down      = n_len[2];
    assign o_job.pause     = n_len[3];
    assign o_job.bridge_on = n_on;

endmodule

@@ hdl/hps_fifo.sv @@
// Short job queue between front and back
module hps_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hps_pkg::t_job i_data,
    input  logic          i_pop,
    output hps_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    import hps_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ hdl/hps_back.sv @@
// Back part: position divider, phase sequencer and driver frame output
module hps_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_job_valid,
    input  hps_pkg::t_job             i_job,
    output logic                      o_job_pop,
    input  logic                      i_cfg_we,
    input  logic [15:0]               i_cfg_wdata,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic [15:0]               o_frame,
    output logic [1:0]                o_chip_index,
    output logic                      o_last
);
    import hps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIV    = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    localparam logic [1:0] PH_REST = 2'd0;
    localparam logic [1:0] PH_FWD  = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;
    localparam logic [1:0] PH_REV  = 2'd3;

    t_state             r_state;
    logic [31:0]        r_time;
    logic [17:0]        r_rem;
    logic [17:0]        r_period;
    logic [4:0]         r_step;
    logic [15:0]        r_up, r_gap, r_down;
    logic [BRIDGES-1:0] r_on;
    logic [5:0]         r_drv [CHIPS];
    logic [1:0]         r_phase;
    logic [CHIP_W-1:0]  r_chip;
    logic [15:0]        r_min;

    logic [18:0]        trial;
    logic [17:0]        pos, edge_up, edge_gap, edge_down;
    logic               go_fwd, go_gap, go_rev, go_rest;

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    // One restoring division step per cycle
    assign trial = {r_rem, r_time[31]};

    // Phase boundaries within the period
    always_comb begin
        pos       = (r_period == 18'd0) ? 18'd0 : r_rem;
        edge_up   = 18'(r_up);
        edge_gap  = edge_up + 18'(r_gap);
        edge_down = edge_gap + 18'(r_down);
        go_fwd  = (pos < edge_up) && (r_phase == PH_REST || r_phase == PH_REV);
        go_gap  = !go_fwd && (pos >= edge_up) && (r_phase <= PH_FWD);
        go_rev  = !go_fwd && !go_gap && (pos >= edge_gap) && (r_phase <= PH_GAP);
        go_rest = !go_fwd && !go_gap && !go_rev && (pos >= edge_down);
    end

    // Hold the phase threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 16'd0;
        end else if (i_cfg_we) begin
            r_min <= i_cfg_wdata;
        end
    end

    // Load jobs and run the divider
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_time   <= i_job.time_now;
            r_rem    <= 18'd0;
            r_step   <= 5'd0;
            r_up     <= i_job.up;
            r_gap    <= i_job.gap;
            r_down   <= i_job.down;
            r_on     <= i_job.bridge_on;
            r_period <= 18'(i_job.up) + 18'(i_job.gap) + 18'(i_job.down) + 18'(i_job.pause);
        end else if (r_state == S_DIV) begin
            r_time <= {r_time[30:0], 1'b0};
            r_step <= r_step + 5'd1;
            if (trial >= {1'b0, r_period}) begin
                r_rem <= 18'(trial - {1'b0, r_period});
            end else begin
                r_rem <= trial[17:0];
            end
        end
    end

    // Sequence phases and step through the frame burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_REST;
            r_chip  <= '0;
            for (int c = 0; c < CHIPS; c++) begin
                r_drv[c] <= 6'd0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == 5'd31) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_IDLE;
                    r_chip  <= CHIP_W'(CHIPS - 1);
                    if (go_fwd || go_rev) begin
                        for (int c = 0; c < CHIPS; c++) begin
                            for (int j = 0; j < 3; j++) begin
                                r_drv[c][j]   <= r_on[3*c+j];
                                r_drv[c][j+3] <= go_rev;
                            end
                        end
                    end else if (go_gap || go_rest) begin
                        for (int c = 0; c < CHIPS; c++) begin
                            r_drv[c] <= 6'd0;
                        end
                    end
                    if (go_fwd) begin
                        r_phase <= PH_FWD;
                        if (r_up > r_min) begin
                            r_state <= S_EMIT;
                        end
                    end else if (go_gap) begin
                        r_phase <= PH_GAP;
                        r_state <= S_EMIT;
                    end else if (go_rev) begin
                        r_phase <= PH_REV;
                        if (r_down > r_min) begin
                            r_state <= S_EMIT;
                        end
                    end else if (go_rest) begin
                        r_phase <= PH_REST;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_pop) begin
                        if (r_chip == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_chip <= r_chip - CHIP_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Present the current frame
    assign o_empty      = (r_state != S_EMIT);
    assign o_frame      = frame_of(r_drv[r_chip]);
    assign o_chip_index = r_chip[1:0];
    assign o_last       = (r_chip == '0);

endmodule

@@ hdl/hbridge_pulse_sequencer_unit.sv @@
// Top level of the H-bridge pulse sequencer
//
// Input channel: one item per control loop pass (i_func, i_rx_byte, i_time_now),
// taken at a clock edge with push high and full low. A received byte updates
// the phase lengths or bridge states at once; the pass then queues for the
// phase sequencer in a two-entry job queue.
// Result channel: driver words (o_frame, o_chip_index, o_last) shown while
// empty is low, taken at an edge with pop high. A phase change gives one burst
// of one word per chip, highest chip first, o_last on chip 0 (forward/reverse
// only above the minimum pulse length that i_cfg_we writes from i_cfg_wdata).
// Operation: the position is time modulo period from a restoring divider, one
// bit a cycle; each item passes the back part as load, 32 divider steps and
// decision, then one word per pop, and the back part takes no new item before
// its burst ends. A stalled result stalls the back part only; the
// front keeps taking items until the job queue fills.
// Reset (synchronous, active low) restores default lengths 1000/0/1000/0,
// all bridges off, rest phase, threshold 0, empties the job queue and the result.
module hbridge_pulse_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_time_now,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_frame,
    output logic [1:0]  o_chip_index,
    output logic        o_last
);
    import hps_pkg::*;

    t_job front_job, back_job;
    logic accept, q_empty, q_pop;

    assign accept = push && !full;

    hps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_func     (i_func),
        .i_rx_byte  (i_rx_byte),
        .i_time_now (i_time_now),
        .o_job      (front_job)
    );

    hps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_data  (back_job),
        .o_full  (full),
        .o_empty (q_empty)
    );

    hps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!q_empty),
        .i_job        (back_job),
        .o_job_pop    (q_pop),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_frame      (o_frame),
        .o_chip_index (o_chip_index),
        .o_last       (o_last)
    );

endmodule

@@ hdl/hps_checker.sv @@
// Port-level checker of the H-bridge pulse sequencer and its bind
`include "hbridge_pulse_sequencer_unit_macros.svh"

module hps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        i_func,
    input logic [7:0]  i_rx_byte,
    input logic [31:0] i_time_now,
    input logic        i_cfg_we,
    input logic [15:0] i_cfg_wdata,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_frame,
    input logic [1:0]  o_chip_index,
    input logic        o_last
);

    // Final word of a burst is for chip 0
    `HPS_ASSERT_NOW(a_last_chip0, !empty && o_last, o_chip_index == 2'd0)
    // Unused frame bits stay clear
    `HPS_ASSERT_NOW(a_frame_spare, !empty, o_frame[15:13] == 3'd0 && o_frame[0] == 1'b0)
    // A burst continues after a word that is not the last
    `HPS_ASSERT_NEXT(a_burst_cont, !empty && pop && !o_last, !empty)
    // Nothing follows the last word until the divider has run again
    `HPS_ASSERT_NEXT(a_burst_end, !empty && pop && o_last, empty)
    // A waiting word holds until taken
    `HPS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_frame))

endmodule

bind hbridge_pulse_sequencer_unit hps_checker u_hps_checker (.*);
